>>> hw/rtl/llh_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package llh_pkg;

  localparam int MAX_BINS = 32;
  localparam int BIN_W    = $clog2(MAX_BINS);
  localparam int CNT_W    = 64;
  localparam int NB_W     = 6;
  localparam int SHIFT_W  = $clog2(CNT_W);

  localparam logic [2:0] OP_RECORD     = 3'd0;
  localparam logic [2:0] OP_READ_BIN   = 3'd1;
  localparam logic [2:0] OP_READ_UNDER = 3'd2;
  localparam logic [2:0] OP_READ_OVER  = 3'd3;
  localparam logic [2:0] OP_CLEAR      = 3'd4;

  localparam logic [1:0] OUTC_IN_BIN = 2'd0;
  localparam logic [1:0] OUTC_UNDER  = 2'd1;
  localparam logic [1:0] OUTC_OVER   = 2'd2;

  localparam logic [1:0] REG_BIN_COUNT   = 2'd0;
  localparam logic [1:0] REG_RANGE_START = 2'd1;
  localparam logic [1:0] REG_BIN_WIDTH   = 2'd2;
  localparam logic [1:0] REG_LOG_MODE    = 2'd3;

  localparam logic [NB_W-1:0]  RST_BIN_COUNT   = NB_W'(20);
  localparam logic [CNT_W-1:0] RST_RANGE_START = '0;
  localparam logic [CNT_W-1:0] RST_BIN_WIDTH   = CNT_W'(1000);
  localparam logic             RST_LOG_MODE    = 1'b1;

  typedef struct packed {
    logic             rd_en;
    logic             wr_en;
    logic             clr;
    logic [BIN_W-1:0] addr;
    logic [CNT_W-1:0] wr_data;
  } store_req_t;

endpackage
`default_nettype wire

>>> hw/rtl/linear_or_log_histogram.sv
// Histogram engine for 64-bit samples, linear or power-of-two bins.
// Input channel (in_valid/in_ready) takes one command per transfer: record a
// sample, read a bin, read the underflow or overflow counter, or clear all.
// Each command gives exactly one result transfer on out_valid/out_ready.
// A record that needs a bin index passes through the 64-step restoring divider
// that forms (sample - range_start) / bin_width one quotient bit per cycle,
// followed by a read-modify-write of the bin memory, or by an overflow count
// when the index is past the bins in use. Underflow, overflow on zero width,
// counter reads, clear and a read past the bins in use go straight to the
// result register; a read of a bin in use first reads the bin memory.
// Throughput: one command at a time; in_ready is high only while idle.
// The result sits in an output register, so the next command is taken while
// a finished result still waits; a stalled receiver holds the block only
// when a second result is ready before the first is taken.
// Configuration goes through the APB-style port; the user must write it
// only while idle, which the block does not enforce. Every register write
// clears all counters. Reset (rst_n, synchronous) sets bin_count 20,
// range_start 0, bin_width 1000, log mode, and clears all counters at once.
`timescale 1ns / 1ps
`default_nettype none
module linear_or_log_histogram (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_valid,
  output logic        in_ready,
  input  wire  [2:0]  in_op,
  input  wire  [63:0] in_sample,
  input  wire  [4:0]  in_read_index,
  output logic        out_valid,
  input  wire         out_ready,
  output logic [63:0] out_count_out,
  output logic [1:0]  out_outcome,
  output logic [4:0]  out_bin_hit,
  input  wire         psel,
  input  wire         penable,
  input  wire         pwrite,
  input  wire  [4:0]  paddr,
  input  wire  [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);
  import llh_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_DIV, S_UPD, S_PUT} state_t;

  state_t           state_r, state_nxt;
  logic [2:0]       op_r, op_nxt;
  logic [BIN_W-1:0] addr_r, addr_nxt;
  logic [CNT_W-1:0] res_count_r, res_count_nxt;
  logic [1:0]       res_outc_r, res_outc_nxt;
  logic [BIN_W-1:0] res_hit_r, res_hit_nxt;
  logic [CNT_W-1:0] uf_r, uf_nxt;
  logic [CNT_W-1:0] of_r, of_nxt;
  logic [NB_W-1:0]  bin_count_r, bin_count_nxt;
  logic [CNT_W-1:0] range_start_r, range_start_nxt;
  logic [CNT_W-1:0] bin_width_r, bin_width_nxt;
  logic             log_mode_r, log_mode_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [CNT_W-1:0] out_count_r, out_count_nxt;
  logic [1:0]       out_outc_r, out_outc_nxt;
  logic [BIN_W-1:0] out_hit_r, out_hit_nxt;

  logic               cfg_wr;
  logic [NB_W-1:0]    n_use;
  logic [NB_W-1:0]    n_m1;
  logic               in_xfer;
  logic               div_start;
  logic               div_done;
  logic [CNT_W-1:0]   div_quo;
  logic [SHIFT_W-1:0] div_msb;
  logic               div_nz;
  logic               over;
  logic [BIN_W-1:0]   bin_sel;
  logic [CNT_W-1:0]   store_rd;
  store_req_t         sreq;

  assign cfg_wr   = psel && penable && pwrite && pready;
  assign pready   = 1'b1;
  assign in_ready = (state_r == S_IDLE);
  assign in_xfer  = in_valid && in_ready;

  always_comb begin
    if (bin_count_r == '0) begin
      n_use = NB_W'(1);
    end else if (bin_count_r > NB_W'(MAX_BINS)) begin
      n_use = NB_W'(MAX_BINS);
    end else begin
      n_use = bin_count_r;
    end
  end
  assign n_m1 = n_use - NB_W'(1);

  always_comb begin
    if (log_mode_r) begin
      over    = div_nz && ({1'b0, div_msb} >= (SHIFT_W + 1)'(n_m1));
      bin_sel = div_nz ? BIN_W'(div_msb + SHIFT_W'(1)) : '0;
    end else begin
      over    = (div_quo >= CNT_W'(n_use));
      bin_sel = div_quo[BIN_W-1:0];
    end
  end

  always_comb begin
    case (paddr[4:3])
      REG_BIN_COUNT:   prdata = CNT_W'(bin_count_r);
      REG_RANGE_START: prdata = range_start_r;
      REG_BIN_WIDTH:   prdata = bin_width_r;
      REG_LOG_MODE:    prdata = CNT_W'(log_mode_r);
      default:         prdata = '0;
    endcase
  end

  always_comb begin
    state_nxt       = state_r;
    op_nxt          = op_r;
    addr_nxt        = addr_r;
    res_count_nxt   = res_count_r;
    res_outc_nxt    = res_outc_r;
    res_hit_nxt     = res_hit_r;
    uf_nxt          = uf_r;
    of_nxt          = of_r;
    bin_count_nxt   = bin_count_r;
    range_start_nxt = range_start_r;
    bin_width_nxt   = bin_width_r;
    log_mode_nxt    = log_mode_r;
    out_valid_nxt   = out_valid_r;
    out_count_nxt   = out_count_r;
    out_outc_nxt    = out_outc_r;
    out_hit_nxt     = out_hit_r;
    div_start       = 1'b0;
    sreq.rd_en      = 1'b0;
    sreq.wr_en      = 1'b0;
    sreq.clr        = 1'b0;
    sreq.addr       = addr_r;
    sreq.wr_data    = '0;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    if (cfg_wr) begin
      case (paddr[4:3])
        REG_BIN_COUNT:   bin_count_nxt   = pwdata[NB_W-1:0];
        REG_RANGE_START: range_start_nxt = pwdata;
        REG_BIN_WIDTH:   bin_width_nxt   = pwdata;
        REG_LOG_MODE:    log_mode_nxt    = pwdata[0];
        default:         bin_count_nxt   = bin_count_r;
      endcase
      uf_nxt   = '0;
      of_nxt   = '0;
      sreq.clr = 1'b1;
    end

    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          op_nxt        = in_op;
          res_count_nxt = '0;
          res_outc_nxt  = OUTC_IN_BIN;
          res_hit_nxt   = '0;
          state_nxt     = S_PUT;
          case (in_op)
            OP_RECORD: begin
              if (in_sample < range_start_r) begin
                uf_nxt        = uf_r + CNT_W'(1);
                res_count_nxt = uf_r + CNT_W'(1);
                res_outc_nxt  = OUTC_UNDER;
              end else if (bin_width_r == '0) begin
                of_nxt        = of_r + CNT_W'(1);
                res_count_nxt = of_r + CNT_W'(1);
                res_outc_nxt  = OUTC_OVER;
              end else begin
                div_start = 1'b1;
                state_nxt = S_DIV;
              end
            end
            OP_READ_BIN: begin
              if ({1'b0, in_read_index} < n_use) begin
                addr_nxt   = in_read_index;
                sreq.addr  = in_read_index;
                sreq.rd_en = 1'b1;
                state_nxt  = S_UPD;
              end
            end
            OP_READ_UNDER: res_count_nxt = uf_r;
            OP_READ_OVER:  res_count_nxt = of_r;
            OP_CLEAR: begin
              uf_nxt   = '0;
              of_nxt   = '0;
              sreq.clr = 1'b1;
            end
            default: res_count_nxt = '0;
          endcase
        end
      end
      S_DIV: begin
        if (div_done) begin
          if (over) begin
            of_nxt        = of_r + CNT_W'(1);
            res_count_nxt = of_r + CNT_W'(1);
            res_outc_nxt  = OUTC_OVER;
            state_nxt     = S_PUT;
          end else begin
            addr_nxt   = bin_sel;
            sreq.addr  = bin_sel;
            sreq.rd_en = 1'b1;
            state_nxt  = S_UPD;
          end
        end
      end
      S_UPD: begin
        if (op_r == OP_RECORD) begin
          sreq.wr_en    = 1'b1;
          sreq.wr_data  = store_rd + CNT_W'(1);
          res_count_nxt = store_rd + CNT_W'(1);
          res_hit_nxt   = addr_r;
        end else begin
          res_count_nxt = store_rd;
        end
        state_nxt = S_PUT;
      end
      S_PUT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_count_nxt = res_count_r;
          out_outc_nxt  = res_outc_r;
          out_hit_nxt   = res_hit_r;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      out_valid_r   <= 1'b0;
      uf_r          <= '0;
      of_r          <= '0;
      bin_count_r   <= RST_BIN_COUNT;
      range_start_r <= RST_RANGE_START;
      bin_width_r   <= RST_BIN_WIDTH;
      log_mode_r    <= RST_LOG_MODE;
    end else begin
      state_r       <= state_nxt;
      out_valid_r   <= out_valid_nxt;
      uf_r          <= uf_nxt;
      of_r          <= of_nxt;
      bin_count_r   <= bin_count_nxt;
      range_start_r <= range_start_nxt;
      bin_width_r   <= bin_width_nxt;
      log_mode_r    <= log_mode_nxt;
    end
    op_r        <= op_nxt;
    addr_r      <= addr_nxt;
    res_count_r <= res_count_nxt;
    res_outc_r  <= res_outc_nxt;
    res_hit_r   <= res_hit_nxt;
    out_count_r <= out_count_nxt;
    out_outc_r  <= out_outc_nxt;
    out_hit_r   <= out_hit_nxt;
  end

  llh_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (in_sample - range_start_r),
    .divisor  (bin_width_r),
    .done     (div_done),
    .quotient (div_quo),
    .msb      (div_msb),
    .nonzero  (div_nz)
  );

  llh_store u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (sreq),
    .rd_data (store_rd)
  );

  assign out_valid     = out_valid_r;
  assign out_count_out = out_count_r;
  assign out_outcome   = out_outc_r;
  assign out_bin_hit   = out_hit_r;

endmodule
`default_nettype wire

>>> hw/rtl/llh_div.sv
`timescale 1ns / 1ps
`default_nettype none
module llh_div (
  input  wire                        clk,
  input  wire                        rst_n,
  input  wire                        start,
  input  wire [llh_pkg::CNT_W-1:0]   dividend,
  input  wire [llh_pkg::CNT_W-1:0]   divisor,
  output logic                       done,
  output logic [llh_pkg::CNT_W-1:0]  quotient,
  output logic [llh_pkg::SHIFT_W-1:0] msb,
  output logic                       nonzero
);
  import llh_pkg::*;

  logic [CNT_W-1:0]   rem_r, rem_nxt;
  logic [CNT_W-1:0]   dvd_r, dvd_nxt;
  logic [CNT_W-1:0]   dvs_r, dvs_nxt;
  logic [CNT_W-1:0]   quo_r, quo_nxt;
  logic [SHIFT_W-1:0] cnt_r, cnt_nxt;
  logic [SHIFT_W-1:0] msb_r, msb_nxt;
  logic               seen_r, seen_nxt;
  logic               run_r, run_nxt;
  logic               done_r, done_nxt;
  logic [CNT_W:0]     trial;
  logic [CNT_W:0]     diff;
  logic               ge;

  assign trial = {rem_r, dvd_r[CNT_W-1]};
  assign diff  = trial - {1'b0, dvs_r};
  assign ge    = (trial >= {1'b0, dvs_r});

  always_comb begin
    rem_nxt  = rem_r;
    dvd_nxt  = dvd_r;
    dvs_nxt  = dvs_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    msb_nxt  = msb_r;
    seen_nxt = seen_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = '0;
      dvd_nxt  = dividend;
      dvs_nxt  = divisor;
      quo_nxt  = '0;
      cnt_nxt  = SHIFT_W'(CNT_W - 1);
      seen_nxt = 1'b0;
      run_nxt  = 1'b1;
    end else if (run_r) begin
      rem_nxt = ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
      dvd_nxt = {dvd_r[CNT_W-2:0], 1'b0};
      quo_nxt = {quo_r[CNT_W-2:0], ge};
      if (ge && !seen_r) begin
        msb_nxt  = cnt_r;
        seen_nxt = 1'b1;
      end
      if (cnt_r == '0) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r - SHIFT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
    end
    rem_r  <= rem_nxt;
    dvd_r  <= dvd_nxt;
    dvs_r  <= dvs_nxt;
    quo_r  <= quo_nxt;
    cnt_r  <= cnt_nxt;
    msb_r  <= msb_nxt;
    seen_r <= seen_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;
  assign msb      = msb_r;
  assign nonzero  = seen_r;

endmodule
`default_nettype wire

>>> hw/rtl/llh_store.sv
`timescale 1ns / 1ps
`default_nettype none
module llh_store (
  input  wire                       clk,
  input  wire                       rst_n,
  input  llh_pkg::store_req_t       req,
  output logic [llh_pkg::CNT_W-1:0] rd_data
);
  import llh_pkg::*;

  logic [CNT_W-1:0]    mem [MAX_BINS];
  logic [MAX_BINS-1:0] vld_r;
  logic [CNT_W-1:0]    rd_data_r;
  logic                rd_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (req.clr) begin
      vld_r <= '0;
    end else if (req.wr_en) begin
      vld_r[req.addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data_r <= mem[req.addr];
      rd_vld_r  <= vld_r[req.addr];
    end
  end

  // entries never written since the last clear read as zero
  assign rd_data = rd_vld_r ? rd_data_r : '0;

endmodule
`default_nettype wire

>>> hw/rtl/llh_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module llh_checker (
  input wire        clk,
  input wire        rst_n,
  input wire        in_valid,
  input wire        in_ready,
  input wire        out_valid,
  input wire        out_ready,
  input wire [63:0] out_count_out,
  input wire [1:0]  out_outcome,
  input wire [4:0]  out_bin_hit,
  input wire        pready
);
  import llh_pkg::*;

  // one command in flight: busy right after an input transfer
  a_busy_after_xfer: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input taken while a command is in flight");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_count_out)
      && $stable(out_outcome) && $stable(out_bin_hit)))
    else $error("stalled result changed");

  a_outcome_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_outcome == OUTC_IN_BIN || out_outcome == OUTC_UNDER
      || out_outcome == OUTC_OVER))
    else $error("bad outcome code");

  a_hit_only_in_bin: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_outcome != OUTC_IN_BIN) |-> (out_bin_hit == '0))
    else $error("bin hit set on underflow or overflow");

  a_pready: assert property (@(posedge clk) disable iff (!rst_n)
    pready)
    else $error("pready low");

endmodule

bind linear_or_log_histogram llh_checker u_llh_checker (.*);
`default_nettype wire
